/* hw/rtl/touch_strip_gesture_recognizer_defines.svh */
// Assertion macros for the touch strip gesture recognizer.
// No dependencies; included by files that carry concurrent checks.
`ifndef TOUCH_STRIP_GESTURE_RECOGNIZER_DEFINES_SVH
`define TOUCH_STRIP_GESTURE_RECOGNIZER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TSGR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define TSGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/tsgr_pkg.sv */
// Shared types, constants and codes for the touch strip gesture recognizer.
// No dependencies.
package tsgr_pkg;

	// gesture codes
	localparam logic [2:0] GEST_NONE    = 3'd0;
	localparam logic [2:0] GEST_PRESS   = 3'd1;
	localparam logic [2:0] GEST_RELEASE = 3'd2;
	localparam logic [2:0] GEST_FWD     = 3'd3;
	localparam logic [2:0] GEST_BACK    = 3'd4;
	localparam logic [2:0] GEST_LONG    = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_SWIPE_THR = 2'd0;
	localparam logic [1:0] REG_LONG_MS   = 2'd1;
	localparam logic [1:0] REG_POLL_MS   = 2'd2;

	// register reset values
	localparam logic [7:0]  RST_SWIPE_THR = 8'd30;
	localparam logic [15:0] RST_LONG_MS   = 16'd1000;
	localparam logic [9:0]  RST_POLL_MS   = 10'd20;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// one queued sample
	typedef struct packed {
		logic [31:0] now;
		logic [1:0]  z0;
		logic [1:0]  z1;
		logic [1:0]  z2;
		logic        skip;
	} entry_t;

	// configuration seen by the back end
	typedef struct packed {
		logic [7:0]  swipe_thr;
		logic [15:0] long_ms;
	} back_cfg_t;

	// queue status toward the back end
	typedef struct packed {
		logic   empty;
		entry_t head;
	} queue_stat_t;

endpackage

/* hw/rtl/touch_strip_gesture_recognizer.sv */
// Top level of the touch strip gesture recognizer: registers, front, queue, back.
// Depends on tsgr_pkg, tsgr_front, tsgr_fifo, tsgr_back and the defines header.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, time_ms, zone_sts | sample in
//  out     | out_valid, out_stall, gesture, ...    | result out
//  cfg     | cfg_valid, cfg_ready, cfg_index, data | register write
//
// One result word per sample. The back end pops a sample, runs the 3-bit-per-cycle
// position divider and loads the result, waiting while out_stall holds the last
// one; samples dropped by the poll check skip the divider. The front takes a word
// per cycle until the queue is full. Reset is asynchronous and clears all control
// state; in_stall rises only on a full queue, out_stall holds the result and back end.
`include "touch_strip_gesture_recognizer_defines.svh"

module touch_strip_gesture_recognizer #(
	parameter int QUEUE_DEPTH = tsgr_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [31:0]       time_ms,
	input  logic [7:0]        zone_status,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        gesture,
	output logic signed [7:0] position,
	output logic              touched,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	logic [7:0]  swipe_thr_q;
	logic [15:0] long_ms_q;
	logic [9:0]  poll_ms_q;

	logic                  push;
	logic                  pop;
	logic                  queue_full;
	tsgr_pkg::entry_t      push_word;
	tsgr_pkg::queue_stat_t qstat;
	tsgr_pkg::back_cfg_t   bcfg;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swipe_thr_q <= tsgr_pkg::RST_SWIPE_THR;
			long_ms_q   <= tsgr_pkg::RST_LONG_MS;
			poll_ms_q   <= tsgr_pkg::RST_POLL_MS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tsgr_pkg::REG_SWIPE_THR: swipe_thr_q <= cfg_data[7:0];
				tsgr_pkg::REG_LONG_MS:   long_ms_q   <= cfg_data;
				tsgr_pkg::REG_POLL_MS:   poll_ms_q   <= cfg_data[9:0];
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	assign bcfg.swipe_thr = swipe_thr_q;
	assign bcfg.long_ms   = long_ms_q;

	tsgr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.time_ms     (time_ms),
		.zone_status (zone_status),
		.poll_ms     (poll_ms_q),
		.queue_full  (queue_full),
		.in_stall    (in_stall),
		.push        (push),
		.push_word   (push_word)
	);

	tsgr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.full      (queue_full),
		.stat      (qstat)
	);

	tsgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (bcfg),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.gesture   (gesture),
		.position  (position),
		.touched   (touched)
	);

	// an untouched sample gives no press, swipe or long press
	`TSGR_ASSERT_NOW(a_untouched_gest, clk, arst_n, out_valid && !touched, gesture == tsgr_pkg::GEST_NONE || gesture == tsgr_pkg::GEST_RELEASE, "gesture without touch")
	// a touched sample never reports release
	`TSGR_ASSERT_NOW(a_touched_no_rel, clk, arst_n, out_valid && touched, gesture != tsgr_pkg::GEST_RELEASE, "release while touched")
	// no touch means centered position
	`TSGR_ASSERT_NOW(a_untouched_pos, clk, arst_n, out_valid && !touched, position == 8'sd0, "position without touch")
	// queue never overrun or popped empty
	`TSGR_ASSERT_NOW(a_queue_ok, clk, arst_n, push || pop, !(push && queue_full) && !(pop && qstat.empty), "queue misuse")
endmodule

/* hw/rtl/tsgr_fifo.sv */
// Small flop-based word queue between front and back.
// Depends on tsgr_pkg.
module tsgr_fifo #(
	parameter int DEPTH = tsgr_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tsgr_pkg::entry_t      push_word,
	input  logic                  pop,
	output logic                  full,
	output tsgr_pkg::queue_stat_t stat
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	tsgr_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign stat.head = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

/* hw/rtl/tsgr_front.sv */
// Front end: takes samples, applies the poll interval, splits the zones.
// Depends on tsgr_pkg.
module tsgr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [31:0]      time_ms,
	input  logic [7:0]       zone_status,
	input  logic [9:0]       poll_ms,
	input  logic             queue_full,
	output logic             in_stall,
	output logic             push,
	output tsgr_pkg::entry_t push_word
);
	logic [31:0] last_q;
	logic [31:0] elapsed;
	logic        skip;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	// wrap-safe elapsed time since the last taken sample
	assign elapsed = time_ms - last_q;
	assign skip    = (elapsed < {22'd0, poll_ms});

	assign push_word.now  = time_ms;
	assign push_word.z0   = skip ? 2'd0 : zone_status[1:0];
	assign push_word.z1   = skip ? 2'd0 : zone_status[3:2];
	assign push_word.z2   = skip ? 2'd0 : zone_status[5:4];
	assign push_word.skip = skip;

	// timestamp of the last sample that passed the poll check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (push && !skip) begin
			last_q <= time_ms;
		end
	end
endmodule

/* hw/rtl/tsgr_back.sv */
// Back end: position divider, gesture state machine and output register.
// Depends on tsgr_pkg.
module tsgr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsgr_pkg::back_cfg_t   cfg,
	input  tsgr_pkg::queue_stat_t qstat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            gesture,
	output logic signed [7:0]     position,
	output logic                  touched
);
	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// gesture phases
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_TOUCHED = 2'd1;
	localparam logic [1:0] PH_SWIPING = 2'd2;

	localparam int BITS_PER_CYC = 3;
	localparam logic [1:0] DIV_LAST = 2'd2;

	logic [1:0]       st_q;
	tsgr_pkg::entry_t ent_q;
	logic [8:0]       dvd_q;
	logic [3:0]       rem_q;
	logic [8:0]       quo_q;
	logic [3:0]       dvs_q;
	logic             neg_q;
	logic [1:0]       cnt_q;

	logic [1:0]        phase_q;
	logic signed [7:0] start_pos_q;
	logic [31:0]       start_time_q;
	logic              lp_done_q;

	logic              out_valid_q;
	logic [2:0]        gest_q;
	logic signed [7:0] pos_q;
	logic              touched_q;

	// divisor and dividend of the head word
	logic [3:0]  h_total;
	logic [2:0]  h_diff;
	logic        h_neg;
	logic [8:0]  h_mag;

	// divider step outputs
	logic [3:0] rem_d;
	logic [8:0] dvd_d;
	logic [8:0] quo_d;

	// result and state machine
	logic              t_w;
	logic signed [7:0] pos_w;
	logic [7:0]        qmag;
	logic signed [9:0] delta;
	logic signed [9:0] thr_p;
	logic signed [9:0] thr_n;
	logic [31:0]       held;
	logic [2:0]        gest_w;
	logic [1:0]        phase_d;
	logic              lp_done_d;
	logic              take;
	logic              load;

	assign pop  = (st_q == ST_IDLE) && !qstat.empty;
	assign take = !out_valid_q || !out_stall;
	assign load = (st_q == ST_DONE) && take;

	// numerator 100*(z2-z0) split into sign and magnitude
	always_comb begin
		h_total = {2'b00, qstat.head.z0} + {2'b00, qstat.head.z1} + {2'b00, qstat.head.z2};
		h_neg   = (qstat.head.z0 > qstat.head.z2);
		h_diff  = h_neg ? ({1'b0, qstat.head.z0} - {1'b0, qstat.head.z2})
		                : ({1'b0, qstat.head.z2} - {1'b0, qstat.head.z0});
		h_mag   = {6'd0, h_diff} * 9'd100;
	end

	// restoring divider, three quotient bits a cycle
	always_comb begin
		logic [4:0] r;
		rem_d = rem_q;
		dvd_d = dvd_q;
		quo_d = quo_q;
		for (int k = 0; k < BITS_PER_CYC; k++) begin
			r = {rem_d, dvd_d[8]};
			dvd_d = {dvd_d[7:0], 1'b0};
			if (r >= {1'b0, dvs_q}) begin
				rem_d = 4'(r - {1'b0, dvs_q});
				quo_d = {quo_d[7:0], 1'b1};
			end else begin
				rem_d = r[3:0];
				quo_d = {quo_d[7:0], 1'b0};
			end
		end
	end

	// signed position, truncated toward zero
	always_comb begin
		t_w   = !ent_q.skip && ((ent_q.z0 | ent_q.z1 | ent_q.z2) != 2'd0);
		qmag  = {1'b0, quo_q[6:0]};
		pos_w = 8'sd0;
		if (t_w) begin
			pos_w = neg_q ? $signed(-qmag) : $signed(qmag);
		end
	end

	// gesture state machine
	always_comb begin
		delta     = 10'(pos_w) - 10'(start_pos_q);
		thr_p     = $signed({2'b00, cfg.swipe_thr});
		thr_n     = -thr_p;
		held      = ent_q.now - start_time_q;
		gest_w    = tsgr_pkg::GEST_NONE;
		phase_d   = phase_q;
		lp_done_d = lp_done_q;
		unique case (phase_q)
			PH_TOUCHED: begin
				if (!t_w) begin
					phase_d = PH_IDLE;
					gest_w  = tsgr_pkg::GEST_RELEASE;
				end else if (delta > thr_p) begin
					phase_d = PH_SWIPING;
					gest_w  = tsgr_pkg::GEST_FWD;
				end else if (delta < thr_n) begin
					phase_d = PH_SWIPING;
					gest_w  = tsgr_pkg::GEST_BACK;
				end else if (!lp_done_q && (held >= {16'd0, cfg.long_ms})) begin
					lp_done_d = 1'b1;
					gest_w    = tsgr_pkg::GEST_LONG;
				end
			end
			PH_SWIPING: begin
				if (!t_w) begin
					phase_d = PH_IDLE;
					gest_w  = tsgr_pkg::GEST_RELEASE;
				end
			end
			default: begin
				// idle, and the unused code treated as idle
				phase_d = PH_IDLE;
				if (t_w) begin
					phase_d   = PH_TOUCHED;
					lp_done_d = 1'b0;
					gest_w    = tsgr_pkg::GEST_PRESS;
				end
			end
		endcase
		if (ent_q.skip) begin
			gest_w    = tsgr_pkg::GEST_NONE;
			phase_d   = phase_q;
			lp_done_d = lp_done_q;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (pop) begin
						st_q  <= qstat.head.skip ? ST_DONE : ST_DIV;
						cnt_q <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working word and divider registers
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= qstat.head;
			dvd_q <= h_mag;
			dvs_q <= h_total;
			neg_q <= h_neg;
			rem_q <= '0;
			quo_q <= '0;
		end else if (st_q == ST_DIV) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	// gesture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			start_pos_q  <= '0;
			start_time_q <= '0;
			lp_done_q    <= 1'b0;
		end else if (load) begin
			phase_q   <= phase_d;
			lp_done_q <= lp_done_d;
			if (gest_w == tsgr_pkg::GEST_PRESS) begin
				start_pos_q  <= pos_w;
				start_time_q <= ent_q.now;
			end
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (load) begin
			gest_q    <= gest_w;
			pos_q     <= pos_w;
			touched_q <= t_w;
		end
	end

	assign out_valid = out_valid_q;
	assign gesture   = gest_q;
	assign position  = pos_q;
	assign touched   = touched_q;
endmodule
